// File: rtl/core/at_rlc_pkg.sv
// Shared types, reply texts and event codes of the AT response line classifier.
package at_rlc_pkg;

    // Item commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    // Event bit positions
    localparam int EV_OK      = 0;
    localparam int EV_ERROR   = 1;
    localparam int EV_FAIL    = 2;
    localparam int EV_BUSY    = 3;
    localparam int EV_WCONN   = 4;
    localparam int EV_GOTIP   = 5;
    localparam int EV_STATUS  = 6;
    localparam int EV_SENDOK  = 8;
    localparam int EV_PROMPT  = 9;
    localparam int EV_CLOSED  = 10;
    localparam int EV_TIMEOUT = 11;

    localparam int WANT_W  = 11;
    localparam int EVENT_W = 12;
    localparam int LIMIT_W = 16;
    localparam int ELAPSED_W = 17;
    localparam logic [ELAPSED_W-1:0] ELAPSED_TOP = '1;

    localparam logic [7:0]  CHAR_CR = 8'h0D;
    localparam logic [7:0]  CHAR_LF = 8'h0A;
    localparam logic [31:0] PROMPT_WORD = 32'h0D0A3E20;

    // Only the first CMP_LEN characters of a line can matter: the longest reply has 14
    localparam int CMP_LEN = 14;
    localparam int TXT_W   = 8 * CMP_LEN;

    typedef logic [CMP_LEN-1:0][7:0] t_chars;
    typedef logic [TXT_W-1:0]        t_txt;
    typedef logic [3:0]              t_txt_len;

    localparam t_txt TXT_OK     = "OK";
    localparam t_txt TXT_ERROR  = "ERROR";
    localparam t_txt TXT_FAIL   = "FAIL";
    localparam t_txt TXT_BUSYP  = "busy p...";
    localparam t_txt TXT_BUSYS  = "busy s...";
    localparam t_txt TXT_GOTIP  = "WIFI GOT IP";
    localparam t_txt TXT_WCONN  = "WIFI CONNECTED";
    localparam t_txt TXT_SENDOK = "SEND OK";
    localparam t_txt TXT_STATUS = "STATUS:2";
    localparam t_txt TXT_CLOSED = "CLOSED";

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         rx_byte;
        logic [WANT_W-1:0]  expected_flags;
        logic [LIMIT_W-1:0] wait_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [EVENT_W-1:0] event_flags;
    } t_out_item;

    // Line unit control for one item
    typedef struct packed {
        logic       clear;
        logic       take;
        logic [7:0] data;
    } t_line_ctl;

    // Raw text matches of the current line (length checked)
    typedef struct packed {
        logic ok;
        logic error;
        logic fail;
        logic busy;
        logic wconn;
        logic gotip;
        logic status2;
        logic sendok;
        logic closed;
    } t_match;

    // Compare the first n characters of a line with a right-aligned text
    function automatic logic txt_match(t_chars c, t_txt txt, t_txt_len n);
        logic same;
        int   pos;
        same = 1'b1;
        for (int i = 0; i < CMP_LEN; i++) begin
            pos = (i < int'(n)) ? (int'(n) - 1 - i) : 0;
            if (i < int'(n) && c[i] != txt[8*pos +: 8]) begin
                same = 1'b0;
            end
        end
        return same;
    endfunction

endpackage

// File: rtl/core/at_rlc_match.sv
// Line compare against the fixed module replies.
module at_rlc_match import at_rlc_pkg::*; #(
    parameter int LEN_W = 5
) (
    input  t_chars           i_chars,
    input  logic [LEN_W-1:0] i_len,
    output t_match           o_match
);

    function automatic logic len_is(logic [LEN_W-1:0] l, t_txt_len n);
        return l == LEN_W'(n);
    endfunction

    always_comb begin
        o_match.ok      = len_is(i_len, 4'd2)  && txt_match(i_chars, TXT_OK, 4'd2);
        o_match.error   = len_is(i_len, 4'd5)  && txt_match(i_chars, TXT_ERROR, 4'd5);
        o_match.fail    = len_is(i_len, 4'd4)  && txt_match(i_chars, TXT_FAIL, 4'd4);
        o_match.busy    = len_is(i_len, 4'd9)  && (txt_match(i_chars, TXT_BUSYP, 4'd9)
                                                || txt_match(i_chars, TXT_BUSYS, 4'd9));
        o_match.wconn   = len_is(i_len, 4'd14) && txt_match(i_chars, TXT_WCONN, 4'd14);
        o_match.gotip   = len_is(i_len, 4'd11) && txt_match(i_chars, TXT_GOTIP, 4'd11);
        o_match.status2 = len_is(i_len, 4'd8)  && txt_match(i_chars, TXT_STATUS, 4'd8);
        o_match.sendok  = len_is(i_len, 4'd7)  && txt_match(i_chars, TXT_SENDOK, 4'd7);
        o_match.closed  = len_is(i_len, 4'd6)  && txt_match(i_chars, TXT_CLOSED, 4'd6);
    end

endmodule

// File: rtl/core/at_rlc_line.sv
// Line splitter: CR-LF framing, line buffer, prompt detect and reply events.
module at_rlc_line import at_rlc_pkg::*; #(
    parameter int LINE_MAX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_line_ctl         i_ctl,
    input  logic [WANT_W-1:0] i_wanted,
    output logic [WANT_W-1:0] o_hits
);

    localparam int LEN_W = $clog2(LINE_MAX + 2);
    typedef logic [LEN_W-1:0] t_len;

    logic [7:0]  r_chars [CMP_LEN];
    t_len        r_len, n_len;
    logic [31:0] r_last, n_last;
    logic        r_cr, n_cr;
    logic        r_stop, n_stop;

    t_chars      chars;
    t_match      match;
    logic [31:0] shifted;
    logic        is_cr, is_lf, line_end, wr_en, put_cr, put_b;
    t_len        len1;

    // Advance length by one character; past the limit the line is marked too long
    function automatic t_len len_step(t_len l);
        return (l < LEN_W'(LINE_MAX)) ? t_len'(l + 1'b1) : t_len'(LINE_MAX + 1);
    endfunction

    always_comb begin
        for (int k = 0; k < CMP_LEN; k++) begin
            chars[k] = r_chars[k];
        end
    end

    at_rlc_match #(
        .LEN_W (LEN_W)
    ) u_match (
        .i_chars (chars),
        .i_len   (r_len),
        .o_match (match)
    );

    assign shifted  = {r_last[23:0], i_ctl.data};
    assign is_cr    = (i_ctl.data == CHAR_CR);
    assign is_lf    = (i_ctl.data == CHAR_LF);
    assign line_end = is_lf && r_cr;
    assign wr_en    = i_ctl.take && !i_ctl.clear && !i_wanted[EV_PROMPT] && !r_stop
                      && !line_end;
    assign put_cr   = r_cr;
    assign put_b    = !is_cr;
    assign len1     = put_cr ? len_step(r_len) : r_len;

    always_comb begin
        n_last = r_last;
        n_len  = r_len;
        n_cr   = r_cr;
        n_stop = r_stop;
        o_hits = '0;
        if (i_ctl.clear) begin
            n_last = '0;
            n_len  = '0;
            n_cr   = 1'b0;
            n_stop = 1'b0;
        end else if (i_ctl.take) begin
            n_last = shifted;
            if (i_wanted[EV_PROMPT]) begin
                o_hits[EV_PROMPT] = (shifted == PROMPT_WORD);
            end else if (!r_stop) begin
                if (line_end) begin
                    o_hits[EV_OK]     = match.ok;
                    o_hits[EV_ERROR]  = match.error;
                    o_hits[EV_FAIL]   = match.fail;
                    o_hits[EV_BUSY]   = match.busy;
                    o_hits[EV_WCONN]  = match.wconn   && i_wanted[EV_WCONN];
                    o_hits[EV_GOTIP]  = match.gotip   && i_wanted[EV_GOTIP];
                    o_hits[EV_STATUS] = match.status2 && i_wanted[EV_STATUS];
                    o_hits[EV_SENDOK] = match.sendok  && i_wanted[EV_SENDOK];
                    o_hits[EV_CLOSED] = match.closed  && i_wanted[EV_CLOSED];
                    n_stop = match.sendok && i_wanted[EV_SENDOK];
                    n_len  = '0;
                    n_cr   = 1'b0;
                end else begin
                    n_len = put_b ? len_step(len1) : len1;
                    n_cr  = is_cr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_len  <= '0;
            r_cr   <= 1'b0;
            r_stop <= 1'b0;
        end else begin
            r_last <= n_last;
            r_len  <= n_len;
            r_cr   <= n_cr;
            r_stop <= n_stop;
        end
    end

    // Line characters beyond the compare window are never needed
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CMP_LEN; k++) begin
            if (wr_en && put_cr && r_len == t_len'(k)) begin
                r_chars[k] <= CHAR_CR;
            end
            if (wr_en && put_b && len1 == t_len'(k)) begin
                r_chars[k] <= i_ctl.data;
            end
        end
    end

endmodule

// File: rtl/core/at_response_line_classifier.sv
// Top level of the AT response line classifier: handshake, wait control, timer and verdict.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------------
//   in      | to block  | i_in_valid / o_in_ready  | i_in_item  (command, rx_byte, mask, ms)
//   out     | from block| o_out_valid / i_out_ready| o_out_item (status, event_flags)
//
// One item per clock cycle while the output is not stalled. An accepted item sits in the
// input register, is classified by the line unit and judged here, and its result lands
// in the output register, where it is held until the receiver takes it.
// Synchronous active-low reset clears the wait, mask, timer and line control state.
// A stalled output holds the result register and the input register; the input side keeps
// taking one more item while a result waits, and stops only when both registers are full.
module at_response_line_classifier import at_rlc_pkg::*; #(
    parameter int LINE_MAX = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // Input register
    logic      r_in_valid;
    t_in_item  r_in;

    // Result register
    logic      r_out_valid;
    t_out_item r_out, n_out;

    // Wait state
    logic                 r_waiting, n_waiting;
    logic [EVENT_W-1:0]   r_seen, n_seen;
    logic [WANT_W-1:0]    r_wanted, n_wanted;
    logic [LIMIT_W-1:0]   r_limit, n_limit;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;

    logic              fire;
    logic              judge_en;
    logic [EVENT_W-1:0] seen_a;
    logic [WANT_W-1:0]  hits;
    t_line_ctl          line_ctl;

    // Advance when the stage holds an item and the result register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // Line unit sees bytes only while a wait is armed; a start clears it
    assign line_ctl.clear = fire && (r_in.command == CMD_START);
    assign line_ctl.take  = fire && (r_in.command == CMD_BYTE) && r_waiting;
    assign line_ctl.data  = r_in.rx_byte;

    at_rlc_line #(
        .LINE_MAX (LINE_MAX)
    ) u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (line_ctl),
        .i_wanted (r_wanted),
        .o_hits   (hits)
    );

    always_comb begin
        n_waiting = r_waiting;
        n_wanted  = r_wanted;
        n_limit   = r_limit;
        n_elapsed = r_elapsed;
        seen_a    = r_seen;
        judge_en  = 1'b0;
        n_out.status = r_waiting ? ST_WAIT : ST_IDLE;

        // Apply the command
        unique case (r_in.command)
            CMD_START: begin
                n_wanted  = r_in.expected_flags;
                n_limit   = r_in.wait_ms;
                n_elapsed = '0;
                seen_a    = '0;
                judge_en  = 1'b1;
            end
            CMD_BYTE: begin
                if (r_waiting) begin
                    seen_a   = r_seen | {1'b0, hits};
                    judge_en = 1'b1;
                end
            end
            CMD_TICK: begin
                if (r_waiting) begin
                    if (r_elapsed != ELAPSED_TOP) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                    judge_en = 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_seen = seen_a;

        // Judge: error replies win, then a complete mask, then expiry
        if (judge_en) begin
            priority if (seen_a[EV_ERROR] || seen_a[EV_FAIL] || seen_a[EV_BUSY]) begin
                n_waiting    = 1'b0;
                n_out.status = ST_FAIL;
            end else if ((n_wanted & seen_a[WANT_W-1:0]) == n_wanted) begin
                n_waiting    = 1'b0;
                n_out.status = ST_DONE;
            end else if ({1'b0, n_limit} < n_elapsed) begin
                n_seen       = {1'b1, n_wanted};
                n_waiting    = 1'b0;
                n_out.status = ST_FAIL;
            end else begin
                n_waiting    = 1'b1;
                n_out.status = ST_WAIT;
            end
        end

        n_out.event_flags = n_seen;
    end

    // Handshake registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: load on accept, hold on stall
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    // Wait state updates only for a processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= 1'b0;
            r_seen    <= '0;
            r_wanted  <= '0;
            r_limit   <= '0;
            r_elapsed <= '0;
        end else if (fire) begin
            r_waiting <= n_waiting;
            r_seen    <= n_seen;
            r_wanted  <= n_wanted;
            r_limit   <= n_limit;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: tb/at_rlc_checker.sv
// Scoreboard for the AT response line classifier: predicts each item's status and flags.
module at_rlc_checker import at_rlc_pkg::*; #(
    parameter int LINE_CAP = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_live_items,
    output int        o_results,
    output int        o_verdicts,
    output int        o_timeouts
);

    // Shadow of the classifier state
    logic                 waiting_q;
    logic [EVENT_W-1:0]   seen_q;
    logic [WANT_W-1:0]    wanted_q;
    logic [LIMIT_W-1:0]   limit_q;
    logic [ELAPSED_W-1:0] elapsed_q;
    logic [7:0]           line_q [LINE_CAP];
    int                   line_len;
    logic [31:0]          tail_q;
    logic                 cr_q;
    logic                 halted_q;

    t_out_item awaited_results [$];

    function automatic logic line_equals(string txt);
        if (line_len != txt.len()) begin
            return 1'b0;
        end
        for (int i = 0; i < txt.len(); i++) begin
            if (line_q[i] != txt[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Past the line capacity, mark the line as too long so that it matches nothing
    function automatic void store_char(logic [7:0] c);
        if (line_len < LINE_CAP) begin
            line_q[line_len] = c;
            line_len++;
        end else begin
            line_len = LINE_CAP + 1;
        end
    endfunction

    function automatic void close_line();
        if (line_equals("OK")) begin
            seen_q[EV_OK] = 1'b1;
        end else if (line_equals("ERROR")) begin
            seen_q[EV_ERROR] = 1'b1;
        end else if (line_equals("FAIL")) begin
            seen_q[EV_FAIL] = 1'b1;
        end else if (line_equals("busy p...") || line_equals("busy s...")) begin
            seen_q[EV_BUSY] = 1'b1;
        end else if (wanted_q[EV_WCONN] && line_equals("WIFI CONNECTED")) begin
            seen_q[EV_WCONN] = 1'b1;
        end else if (wanted_q[EV_GOTIP] && line_equals("WIFI GOT IP")) begin
            seen_q[EV_GOTIP] = 1'b1;
        end else if (wanted_q[EV_STATUS] && line_equals("STATUS:2")) begin
            seen_q[EV_STATUS] = 1'b1;
        end else if (wanted_q[EV_SENDOK] && line_equals("SEND OK")) begin
            seen_q[EV_SENDOK] = 1'b1;
            halted_q = 1'b1;
        end else if (wanted_q[EV_CLOSED] && line_equals("CLOSED")) begin
            seen_q[EV_CLOSED] = 1'b1;
        end
    endfunction

    function automatic void take_rx(logic [7:0] b);
        tail_q = {tail_q[23:0], b};
        if (wanted_q[EV_PROMPT]) begin
            if (tail_q == PROMPT_WORD) begin
                seen_q[EV_PROMPT] = 1'b1;
            end
            return;
        end
        if (halted_q) begin
            return;
        end
        if (b == CHAR_CR) begin
            if (cr_q) begin
                store_char(CHAR_CR);
            end
            cr_q = 1'b1;
        end else if (b == CHAR_LF && cr_q) begin
            close_line();
            line_len = 0;
            cr_q = 1'b0;
        end else begin
            if (cr_q) begin
                store_char(CHAR_CR);
            end
            store_char(b);
            cr_q = 1'b0;
        end
    endfunction

    function automatic logic [1:0] judge_wait();
        if (seen_q[EV_ERROR] || seen_q[EV_FAIL] || seen_q[EV_BUSY]) begin
            waiting_q = 1'b0;
            return ST_FAIL;
        end
        if ((wanted_q & seen_q[WANT_W-1:0]) == wanted_q) begin
            waiting_q = 1'b0;
            return ST_DONE;
        end
        if (limit_q < elapsed_q) begin
            seen_q = {1'b1, wanted_q};
            waiting_q = 1'b0;
            o_timeouts++;
            return ST_FAIL;
        end
        return ST_WAIT;
    endfunction

    function automatic t_out_item classify_item(t_in_item it);
        t_out_item r;
        logic [1:0] st;
        st = waiting_q ? ST_WAIT : ST_IDLE;
        case (it.command)
            CMD_START: begin
                o_live_items++;
                waiting_q = 1'b1;
                seen_q    = '0;
                wanted_q  = it.expected_flags;
                limit_q   = it.wait_ms;
                elapsed_q = '0;
                line_len  = 0;
                tail_q    = '0;
                cr_q      = 1'b0;
                halted_q  = 1'b0;
                st = judge_wait();
            end
            CMD_BYTE: begin
                if (waiting_q) begin
                    o_live_items++;
                    take_rx(it.rx_byte);
                    st = judge_wait();
                end
            end
            CMD_TICK: begin
                if (waiting_q) begin
                    o_live_items++;
                    if (elapsed_q != ELAPSED_TOP) begin
                        elapsed_q++;
                    end
                    st = judge_wait();
                end
            end
            default: begin
            end
        endcase
        r.status      = st;
        r.event_flags = seen_q;
        return r;
    endfunction

    always @(posedge i_clk) begin : p_score
        t_out_item want;
        if (!i_rst_n) begin
            waiting_q = 1'b0;
            seen_q    = '0;
            wanted_q  = '0;
            limit_q   = '0;
            elapsed_q = '0;
            line_len  = 0;
            tail_q    = '0;
            cr_q      = 1'b0;
            halted_q  = 1'b0;
            awaited_results.delete();
        end else begin
            // Compare first: a result never belongs to an item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with nothing awaited, actual status %0d flags %h",
                             $time, i_out_item.status, i_out_item.event_flags);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.status !== i_out_item.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_out_item.status);
                        o_fail_count++;
                    end
                    if (want.event_flags !== i_out_item.event_flags) begin
                        $display("%0t: event_flags mismatch, expected %h, actual %h",
                                 $time, want.event_flags, i_out_item.event_flags);
                        o_fail_count++;
                    end
                    if (want.status == ST_DONE || want.status == ST_FAIL) begin
                        o_verdicts++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_results.push_back(classify_item(i_in_item));
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// File: tb/tb.sv
// Testbench top for the AT response line classifier: stimulus, idling and final verdict.
module tb import at_rlc_pkg::*; ();

    localparam logic [1:0] CMD_ODD  = 2'd3;   // command code the block has no use for
    localparam int         EV_SPARE = 7;      // mask bit that no reply ever sets
    localparam int LINE_LEN     = 16;
    localparam int ITEM_GOAL    = 1350;
    localparam int QUIET_FROM   = 1200;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 48;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // Replies the line parser knows; entries 1 to 4 end a wait with an error
    localparam logic [WANT_W-1:0] LINE_MASK = WANT_W'((1 << EV_OK) | (1 << EV_WCONN) |
        (1 << EV_GOTIP) | (1 << EV_STATUS) | (1 << EV_SENDOK) | (1 << EV_CLOSED));

    typedef logic [7:0] t_bytes [$];

    string reply_txt [10] = '{"OK", "ERROR", "FAIL", "busy p...", "busy s...",
                              "WIFI GOT IP", "WIFI CONNECTED", "SEND OK", "STATUS:2", "CLOSED"};

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    int   fail_count;
    int   pending;
    int   live_items;
    int   results;
    int   verdicts;
    int   timeouts;
    int   sessions;
    int   sent_items;
    int   cycle_count;
    logic idling_on;
    logic hold_req;
    logic hold_done;

    // 12-unit clock period
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    at_response_line_classifier #(
        .LINE_MAX (LINE_LEN)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    at_rlc_checker #(
        .LINE_CAP (LINE_LEN)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_live_items (live_items),
        .o_results    (results),
        .o_verdicts   (verdicts),
        .o_timeouts   (timeouts)
    );

    // Offer one item and hold it until the block takes it. An optional idle burst
    // comes first; valid otherwise stays high from one item to the next.
    task automatic send_item(logic [1:0] cmd, logic [7:0] rx, logic [WANT_W-1:0] mask,
                             logic [LIMIT_W-1:0] ms);
        t_in_item it;
        int       gap;
        it.command        = cmd;
        it.rx_byte        = rx;
        it.expected_flags = mask;
        it.wait_ms        = ms;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
    endtask

    // Fields a command does not use carry random bits
    task automatic send_start(logic [WANT_W-1:0] mask, logic [LIMIT_W-1:0] ms);
        send_item(CMD_START, 8'($urandom), mask, ms);
        sessions++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(CMD_BYTE, b, WANT_W'($urandom), LIMIT_W'($urandom));
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 8'($urandom), WANT_W'($urandom), LIMIT_W'($urandom));
    endtask

    task automatic send_odd();
        send_item(CMD_ODD, 8'($urandom), WANT_W'($urandom), LIMIT_W'($urandom));
    endtask

    function automatic t_bytes text_bytes(string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    // Send the bytes of a line, now and then with a millisecond tick in between
    task automatic send_line(t_bytes body);
        foreach (body[i]) begin
            if ($urandom_range(0, 19) == 0) begin
                send_tick();
            end
            send_byte(body[i]);
        end
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    // Prompt cursor; a near miss swaps the final character
    task automatic send_prompt(logic exact);
        t_bytes seq;
        for (int i = 3; i >= 0; i--) begin
            seq.push_back(PROMPT_WORD[8*i +: 8]);
        end
        if (!exact && $urandom_range(0, 4) == 0) begin
            seq[3] = 8'($urandom);
        end
        foreach (seq[i]) begin
            send_byte(seq[i]);
        end
    endtask

    // Pick a line: real replies, near misses, lines just under, at and past the capacity,
    // raw bytes (zero, lone CR or LF), empty lines and a line led by a stray CR
    task automatic send_random_line();
        t_bytes body;
        int     pick;
        int     n;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            body = text_bytes(reply_txt[$urandom_range(1, 4)]);
        end else if (pick < 30) begin
            body = text_bytes(reply_txt[0]);
        end else if (pick < 60) begin
            body = text_bytes(reply_txt[$urandom_range(5, 9)]);
        end else if (pick < 70) begin
            n = $urandom_range(LINE_LEN - 1, LINE_LEN + 8);
            repeat (n) body.push_back(8'($urandom_range(32, 126)));
        end else if (pick < 80) begin
            body = text_bytes(reply_txt[$urandom_range(0, 9)]);
            if ($urandom_range(0, 1) == 0) begin
                body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
            end else begin
                void'(body.pop_back());
            end
        end else if (pick < 90) begin
            n = $urandom_range(1, 6);
            repeat (n) body.push_back(8'($urandom));
        end else if (pick >= 95) begin
            body = text_bytes(reply_txt[0]);
            body.push_front(CHAR_CR);
        end
        send_line(body);
    endtask

    // One wait: arm with a random mask and limit, then feed lines, ticks and noise
    task automatic run_session();
        logic [WANT_W-1:0]  mask;
        logic [LIMIT_W-1:0] ms;
        logic               prompt_mode;
        int                 steps;
        int                 pick;
        mask = '0;
        prompt_mode = ($urandom_range(0, 99) < 15);
        if (prompt_mode) begin
            mask[EV_PROMPT] = 1'b1;
            mask[EV_SPARE]  = ($urandom_range(0, 4) == 0);
        end else if ($urandom_range(0, 9) == 0) begin
            mask = WANT_W'($urandom);
        end else begin
            mask = WANT_W'($urandom) & LINE_MASK;
        end
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            ms = LIMIT_W'($urandom_range(0, 8));
        end else if (pick < 8) begin
            ms = LIMIT_W'($urandom_range(50, 65535));
        end else begin
            ms = LIMIT_W'($urandom);
        end
        send_start(mask, ms);
        steps = $urandom_range(1, 10);
        repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (prompt_mode && pick < 40) begin
                send_prompt(1'b0);
            end else if (!prompt_mode && pick < 60) begin
                send_random_line();
            end else if (pick < 75) begin
                send_tick();
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end else if (pick < 97) begin
                send_odd();
            end else begin
                send_random_line();
            end
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off that backs the block up
    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    @(posedge clk);
                end
                out_ready <= 1'b1;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it outlives the cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[at_response_line_classifier] ERROR");
        $finish;
    end

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        idling_on  = 1'b0;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        sessions   = 0;
        sent_items = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle items and the unknown command, then the empty mask
        send_byte(8'hFF);
        send_tick();
        send_odd();
        send_start('0, '0);
        // OK with the longest limit, then an immediate timeout on the shortest
        send_start(WANT_W'(1 << EV_OK), '1);
        send_line(text_bytes(reply_txt[0]));
        send_start(WANT_W'(1 << EV_OK), '0);
        send_tick();
        // Prompt cursor, then a zero byte, a lone LF and a FAIL under a full mask
        send_start(WANT_W'(1 << EV_PROMPT), '1);
        send_prompt(1'b1);
        send_start('1, LIMIT_W'(1));
        send_byte(8'h00);
        send_byte(CHAR_LF);
        send_line(text_bytes(reply_txt[2]));

        // Random waits; idling comes and goes, and stops for the last stretch
        while (sent_items < ITEM_GOAL) begin
            idling_on = (sent_items < QUIET_FROM) && ($urandom_range(0, 3) != 0);
            if (sent_items >= HOLD_AT) begin
                hold_req = 1'b1;
            end
            run_session();
        end
        idling_on = 1'b0;

        // Drain: drop valid, let every awaited result arrive, then idle for DRAIN_CYCLES
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d items, %0d of them live, over %0d waits: idle and unknown commands,",
                 sent_items, live_items, sessions);
        $display("prompt, long and broken lines, and a stalled output; %0d results checked, %0d %s",
                 results, verdicts, $sformatf("verdicts (%0d timeouts).", timeouts));
        if (fail_count == 0) begin
            $display("[at_response_line_classifier] OK");
        end else begin
            $display("[at_response_line_classifier] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/at_rlc_pkg.sv
rtl/core/at_rlc_match.sv
rtl/core/at_rlc_line.sv
rtl/core/at_response_line_classifier.sv
tb/at_rlc_checker.sv
tb/tb.sv
